// ===== hw/rtl/qsl_pkg.sv =====
// Shared sizes and widths for the quicksort batch sorter.
`default_nettype none

package qsl_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int RANGE_BITS = 2 * IDX_BITS;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qsl_if.sv =====
// Valid/ready channel interfaces for input items and sorted results.
`default_nettype none

interface qsl_item_if;
  import qsl_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface qsl_result_if;
  import qsl_pkg::*;

  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   end_of_batch;
  logic   overflowed;

  modport source (output valid, output sorted_value, output end_of_batch,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input end_of_batch,
                  input overflowed, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qsl_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module qsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/quicksort_lomuto_engine.sv =====
// Batch sorter: loads one value per cycle, sorts with Lomuto quicksort, emits ascending.
// Sort time grows with each compare of the sort and each range popped from the stack;
// every swap goes through the one-read, one-write element RAM. A new batch is taken
// only once the last result of the previous one has been loaded for output.
// Reset (synchronous, active high) clears count, stack pointer, drop flag and the
// output valid; RAM contents are left as they are.
`default_nettype none

module quicksort_lomuto_engine (
  input wire logic    clk,
  input wire logic    rst,
  qsl_item_if.sink    item,
  qsl_result_if.source result
);
  import qsl_pkg::*;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_POP      = 4'd1;
  localparam logic [3:0] S_POP_WAIT = 4'd2;
  localparam logic [3:0] S_PIVOT    = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CMP = 4'd5;
  localparam logic [3:0] S_SWAP_A   = 4'd6;
  localparam logic [3:0] S_SWAP_B   = 4'd7;
  localparam logic [3:0] S_FIN_A    = 4'd8;
  localparam logic [3:0] S_FIN_B    = 4'd9;
  localparam logic [3:0] S_PUSH_LO  = 4'd10;
  localparam logic [3:0] S_PUSH_HI  = 4'd11;
  localparam logic [3:0] S_EMIT_RD  = 4'd12;
  localparam logic [3:0] S_EMIT_LD  = 4'd13;

  localparam cnt_t CAP_CNT = CNT_BITS'(CAPACITY);
  localparam cnt_t ONE_CNT = CNT_BITS'(1);
  localparam cnt_t TWO_CNT = CNT_BITS'(2);

  logic [3:0] state, state_next;
  cnt_t       count, count_next;
  cnt_t       sp, sp_next;
  logic       dropped, dropped_next;
  idx_t       lo, lo_next;
  idx_t       hi, hi_next;
  idx_t       st, st_next;
  idx_t       j, j_next;
  idx_t       k, k_next;
  value_t     pivot, pivot_next;
  value_t     held, held_next;

  logic   out_valid, out_valid_next;
  value_t out_value, out_value_next;
  logic   out_end, out_end_next;
  logic   out_ovf, out_ovf_next;

  // element store ports
  logic   e_we, e_re;
  idx_t   e_waddr, e_raddr;
  value_t e_wdata, e_rdata;

  // range stack ports
  logic   s_we, s_re;
  idx_t   s_waddr, s_raddr;
  range_t s_wdata, s_rdata;
  logic [RANGE_BITS-1:0] s_rbits;

  logic   item_beat;
  logic   full;
  cnt_t   n_batch;
  logic   less;
  logic   out_free;
  cnt_t   st_ext, lo_ext, hi_ext, k_ext;

  assign item_beat = item.valid && item.ready;
  assign full      = (count >= CAP_CNT);
  assign n_batch   = full ? count : count + ONE_CNT;
  assign less      = $signed(e_rdata) < $signed(pivot);
  assign out_free  = !out_valid || result.ready;
  assign st_ext    = CNT_BITS'(st);
  assign lo_ext    = CNT_BITS'(lo);
  assign hi_ext    = CNT_BITS'(hi);
  assign k_ext     = CNT_BITS'(k);
  assign s_rdata   = range_t'(s_rbits);

  assign item.ready          = (state == S_LOAD);
  assign result.valid        = out_valid;
  assign result.sorted_value = out_value;
  assign result.end_of_batch = out_end;
  assign result.overflowed   = out_ovf;

  always_comb begin
    state_next     = state;
    count_next     = count;
    sp_next        = sp;
    dropped_next   = dropped;
    lo_next        = lo;
    hi_next        = hi;
    st_next        = st;
    j_next         = j;
    k_next         = k;
    pivot_next     = pivot;
    held_next      = held;
    out_valid_next = out_valid && !result.ready;
    out_value_next = out_value;
    out_end_next   = out_end;
    out_ovf_next   = out_ovf;

    e_we    = 1'b0;
    e_waddr = count[IDX_BITS-1:0];
    e_wdata = item.value;
    e_re    = 1'b0;
    e_raddr = j;
    s_we    = 1'b0;
    s_waddr = sp[IDX_BITS-1:0];
    s_wdata = '{lo: lo, hi: st - IDX_BITS'(1)};
    s_re    = 1'b0;
    s_raddr = sp[IDX_BITS-1:0] - IDX_BITS'(1);

    case (state)
      S_LOAD: begin
        if (item_beat) begin
          if (!full) begin
            e_we       = 1'b1;
            count_next = count + ONE_CNT;
          end else begin
            dropped_next = 1'b1;
          end
          if (item.last) begin
            count_next = n_batch;
            k_next     = '0;
            if (n_batch >= TWO_CNT) begin
              s_we       = 1'b1;
              s_waddr    = '0;
              s_wdata    = '{lo: '0, hi: IDX_BITS'(n_batch - ONE_CNT)};
              sp_next    = ONE_CNT;
              state_next = S_POP;
            end else begin
              state_next = S_EMIT_RD;
            end
          end
        end
      end
      S_POP: begin
        if (sp == '0) begin
          k_next     = '0;
          state_next = S_EMIT_RD;
        end else begin
          s_re       = 1'b1;
          sp_next    = sp - ONE_CNT;
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        lo_next    = s_rdata.lo;
        hi_next    = s_rdata.hi;
        e_re       = 1'b1;
        e_raddr    = s_rdata.hi;
        state_next = S_PIVOT;
      end
      S_PIVOT: begin
        pivot_next = e_rdata;
        st_next    = lo;
        j_next     = lo;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        e_re = 1'b1;
        if (j == hi) begin
          // scan done: fetch the slot the pivot goes to
          e_raddr    = st;
          state_next = S_FIN_A;
        end else begin
          e_raddr    = j;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (less && st != j) begin
          held_next  = e_rdata;
          e_re       = 1'b1;
          e_raddr    = st;
          state_next = S_SWAP_A;
        end else begin
          if (less) begin
            st_next = st + IDX_BITS'(1);
          end
          j_next     = j + IDX_BITS'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_SWAP_A: begin
        e_we       = 1'b1;
        e_waddr    = st;
        e_wdata    = held;
        state_next = S_SWAP_B;
      end
      S_SWAP_B: begin
        e_we       = 1'b1;
        e_waddr    = j;
        e_wdata    = e_rdata;
        st_next    = st + IDX_BITS'(1);
        j_next     = j + IDX_BITS'(1);
        state_next = S_SCAN_RD;
      end
      S_FIN_A: begin
        e_we       = 1'b1;
        e_waddr    = hi;
        e_wdata    = e_rdata;
        state_next = S_FIN_B;
      end
      S_FIN_B: begin
        e_we       = 1'b1;
        e_waddr    = st;
        e_wdata    = pivot;
        state_next = S_PUSH_LO;
      end
      S_PUSH_LO: begin
        // left part [lo, p-1] when it holds two or more entries and the stack is not full
        if (st_ext > lo_ext + ONE_CNT && sp < CAP_CNT) begin
          s_we    = 1'b1;
          s_wdata = '{lo: lo, hi: st - IDX_BITS'(1)};
          sp_next = sp + ONE_CNT;
        end
        state_next = S_PUSH_HI;
      end
      S_PUSH_HI: begin
        if (st_ext + ONE_CNT < hi_ext && sp < CAP_CNT) begin
          s_we    = 1'b1;
          s_wdata = '{lo: st + IDX_BITS'(1), hi: hi};
          sp_next = sp + ONE_CNT;
        end
        state_next = S_POP;
      end
      S_EMIT_RD: begin
        e_re       = 1'b1;
        e_raddr    = k;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_value_next = e_rdata;
          out_end_next   = (k_ext + ONE_CNT == count);
          out_ovf_next   = dropped;
          if (k_ext + ONE_CNT == count) begin
            count_next   = '0;
            sp_next      = '0;
            dropped_next = 1'b0;
            state_next   = S_LOAD;
          end else begin
            k_next     = k + IDX_BITS'(1);
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      sp        <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      sp        <= sp_next;
      dropped   <= dropped_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    st        <= st_next;
    j         <= j_next;
    k         <= k_next;
    pivot     <= pivot_next;
    held      <= held_next;
    out_value <= out_value_next;
    out_end   <= out_end_next;
    out_ovf   <= out_ovf_next;
  end

  qsl_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_element_store (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  qsl_ram #(
    .WIDTH (RANGE_BITS),
    .DEPTH (CAPACITY)
  ) u_range_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (RANGE_BITS'(s_wdata)),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rbits)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/qsl_checker.sv =====
// Port-level checks for the quicksort batch sorter, bound to the top level.
`default_nettype none

module qsl_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            item_ready,
  input wire logic                            result_valid,
  input wire logic                            result_ready,
  input wire logic [qsl_pkg::VALUE_BITS-1:0]  result_sorted_value,
  input wire logic                            result_end_of_batch,
  input wire logic                            result_overflowed
);
  import qsl_pkg::*;

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat withdrawn while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_sorted_value)
      && $stable(result_end_of_batch) && $stable(result_overflowed))
    else $error("result payload changed while stalled");

  // while loading, only the closing beat of the previous batch may still wait
  a_load_overlap: assert property (@(posedge clk) disable iff (rst)
    item_ready && result_valid |-> result_end_of_batch)
    else $error("input taken while a batch is still draining");

endmodule

bind quicksort_lomuto_engine qsl_checker u_qsl_checker (
  .clk                 (clk),
  .rst                 (rst),
  .item_ready          (item.ready),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_sorted_value (result.sorted_value),
  .result_end_of_batch (result.end_of_batch),
  .result_overflowed   (result.overflowed)
);

`default_nettype wire
